// ===== hw/rtl/event_counter_bank_with_change_flags_core_assert.svh =====
`ifndef EVENT_COUNTER_BANK_WITH_CHANGE_FLAGS_CORE_ASSERT_SVH
`define EVENT_COUNTER_BANK_WITH_CHANGE_FLAGS_CORE_ASSERT_SVH

// same-cycle implication, checked on every rising edge outside reset
`define ECBCF_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ECBCF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/ecbcf_pkg.sv =====
`default_nettype none

package ecbcf_pkg;

   localparam int NUM_COUNTERS = 32;
   localparam int IDX_W        = 5;
   localparam int VAL_W        = 63;
   localparam int AMT_W        = 32;
   localparam int MODE_W       = 3;
   localparam int KIND_W       = 2;

   localparam logic [MODE_W-1:0] MODE_ADD       = 3'd0;
   localparam logic [MODE_W-1:0] MODE_READ      = 3'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR_ONE = 3'd2;
   localparam logic [MODE_W-1:0] MODE_CLEAR_ALL = 3'd3;
   localparam logic [MODE_W-1:0] MODE_SCAN      = 3'd4;

   localparam logic [KIND_W-1:0] KIND_ACK   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ENTRY = 2'd2;
   localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_RESP
   } state_type;

endpackage

`default_nettype wire

// ===== hw/rtl/event_counter_bank_with_change_flags_core.sv =====
// channel   | handshake             | payload
// ----------+-----------------------+-------------------------------------------------
// request   | req_valid / req_ready | req_mode, req_index, req_amount, req_changed_only
// response  | rsp_valid / rsp_ready | rsp_kind, rsp_counter_index, rsp_count_value, rsp_last
//
// one transaction at a time: add, read, clear one, clear all and unused modes register the
// memory read at accept, then pass through ST_EXEC (the 63-bit adder for add writes the memory,
// others load the response register) and ST_RESP, where rsp_valid rises, before the next accept
// a report scan visits counters in order through ST_SCAN_RD and ST_SCAN_CHK, plus ST_RESP per
// entry emitted, then returns to idle; it is paced by the single read port of the counter memory
// reset clears the per-entry valid bits and sets all changed flags
// req_ready is low while a transaction is in flight, including while rsp_valid stalls
`default_nettype none

`include "event_counter_bank_with_change_flags_core_assert.svh"

module event_counter_bank_with_change_flags_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [ecbcf_pkg::MODE_W-1:0]      req_mode,
   input  wire logic [ecbcf_pkg::IDX_W-1:0]       req_index,
   input  wire logic signed [ecbcf_pkg::AMT_W-1:0] req_amount,
   input  wire logic                              req_changed_only,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [ecbcf_pkg::KIND_W-1:0]           rsp_kind,
   output logic [ecbcf_pkg::IDX_W-1:0]            rsp_counter_index,
   output logic [ecbcf_pkg::VAL_W-1:0]            rsp_count_value,
   output logic                                   rsp_last
);
   import ecbcf_pkg::*;

   state_type state_ff, state_in;

   logic [MODE_W-1:0]       mode_ff, mode_in;
   logic [IDX_W-1:0]        index_ff, index_in;
   logic signed [AMT_W-1:0] amount_ff, amount_in;
   logic                    only_ff, only_in;
   logic [IDX_W-1:0]        scan_idx_ff, scan_idx_in;
   logic                    scan_cont_ff, scan_cont_in;

   logic [KIND_W-1:0]       kind_ff, kind_in;
   logic [IDX_W-1:0]        ridx_ff, ridx_in;
   logic [VAL_W-1:0]        value_ff, value_in;
   logic                    last_ff, last_in;

   logic [NUM_COUNTERS-1:0] flags_ff, flags_in;
   logic [NUM_COUNTERS-1:0] valid_ff, valid_in;

   logic [VAL_W-1:0]        mem [NUM_COUNTERS];
   logic [VAL_W-1:0]        rd_data_ff;
   logic                    rd_valid_ff;
   logic [IDX_W-1:0]        rd_addr;
   logic                    wr_en;
   logic [VAL_W-1:0]        wr_data;

   logic [VAL_W-1:0]        cur;
   logic [VAL_W-1:0]        amt_ext;
   logic [VAL_W-1:0]        sum;
   logic                    in_range;
   logic                    emit;
   logic                    more_flagged;
   logic                    at_end;

   logic                    rsp_is_entry;
   logic                    rsp_is_empty;
   logic                    clear_all_exec;

   assign cur      = rd_valid_ff ? rd_data_ff : '0;
   assign amt_ext  = {{(VAL_W-AMT_W){amount_ff[AMT_W-1]}}, amount_ff};
   // adder for the add mode
   assign sum      = cur + amt_ext;
   assign in_range = ({1'b0, index_ff} < (IDX_W+1)'(NUM_COUNTERS));
   assign at_end   = (scan_idx_ff == IDX_W'(NUM_COUNTERS-1));
   assign emit     = !only_ff || flags_ff[scan_idx_ff];

   // any flagged counter above the current scan position
   always_comb begin
      more_flagged = 1'b0;
      for (int j = 0; j < NUM_COUNTERS; j++) begin
         if (flags_ff[j] && ((IDX_W+1)'(j) > {1'b0, scan_idx_ff})) begin
            more_flagged = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         flags_ff     <= '1;
         valid_ff     <= '0;
         scan_cont_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         flags_ff     <= flags_in;
         valid_ff     <= valid_in;
         scan_cont_ff <= scan_cont_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      index_ff    <= index_in;
      amount_ff   <= amount_in;
      only_ff     <= only_in;
      scan_idx_ff <= scan_idx_in;
      kind_ff     <= kind_in;
      ridx_ff     <= ridx_in;
      value_ff    <= value_in;
      last_ff     <= last_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[index_ff] <= wr_data;
      end
      rd_data_ff  <= mem[rd_addr];
      rd_valid_ff <= valid_ff[rd_addr];
   end

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      index_in     = index_ff;
      amount_in    = amount_ff;
      only_in      = only_ff;
      scan_idx_in  = scan_idx_ff;
      scan_cont_in = scan_cont_ff;
      kind_in      = kind_ff;
      ridx_in      = ridx_ff;
      value_in     = value_ff;
      last_in      = last_ff;
      flags_in     = flags_ff;
      valid_in     = valid_ff;
      rd_addr      = index_ff;
      wr_en        = 1'b0;
      wr_data      = sum;
      req_ready    = 1'b0;
      rsp_valid    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            rd_addr   = req_index;
            if (req_valid) begin
               mode_in     = req_mode;
               index_in    = req_index;
               amount_in   = req_amount;
               only_in     = req_changed_only;
               scan_idx_in = '0;
               state_in    = (req_mode == MODE_SCAN) ? ST_SCAN_RD : ST_EXEC;
            end
         end
         ST_EXEC: begin
            kind_in      = KIND_ACK;
            ridx_in      = '0;
            value_in     = '0;
            last_in      = 1'b1;
            scan_cont_in = 1'b0;
            state_in     = ST_RESP;
            unique case (mode_ff)
               MODE_ADD: begin
                  if (in_range && (amount_ff != '0)) begin
                     wr_en              = 1'b1;
                     valid_in[index_ff] = 1'b1;
                     flags_in[index_ff] = 1'b1;
                  end
               end
               MODE_READ: begin
                  kind_in  = KIND_READ;
                  ridx_in  = index_ff;
                  value_in = in_range ? cur : '0;
               end
               MODE_CLEAR_ONE: begin
                  // a cleared entry reads as zero through its valid bit
                  if (in_range && (cur != '0)) begin
                     valid_in[index_ff] = 1'b0;
                     flags_in[index_ff] = 1'b1;
                  end
               end
               MODE_CLEAR_ALL: begin
                  valid_in = '0;
                  flags_in = '1;
               end
               default: begin
               end
            endcase
         end
         ST_SCAN_RD: begin
            rd_addr  = scan_idx_ff;
            state_in = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            if (emit) begin
               kind_in               = KIND_ENTRY;
               ridx_in               = scan_idx_ff;
               value_in              = cur;
               last_in               = only_ff ? !more_flagged : at_end;
               scan_cont_in          = only_ff ? more_flagged : !at_end;
               flags_in[scan_idx_ff] = 1'b0;
               state_in              = ST_RESP;
            end else if (at_end) begin
               // reaching the end without an entry means nothing was emitted
               kind_in      = KIND_EMPTY;
               ridx_in      = '0;
               value_in     = '0;
               last_in      = 1'b1;
               scan_cont_in = 1'b0;
               state_in     = ST_RESP;
            end else begin
               scan_idx_in = scan_idx_ff + 1'b1;
               state_in    = ST_SCAN_RD;
            end
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (scan_cont_ff) begin
                  scan_idx_in = scan_idx_ff + 1'b1;
                  state_in    = ST_SCAN_RD;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_kind          = kind_ff;
   assign rsp_counter_index = ridx_ff;
   assign rsp_count_value   = value_ff;
   assign rsp_last          = last_ff;

   assign rsp_is_entry   = rsp_valid && (rsp_kind == KIND_ENTRY);
   assign rsp_is_empty   = rsp_valid && (rsp_kind == KIND_EMPTY);
   assign clear_all_exec = (state_ff == ST_EXEC) && (mode_ff == MODE_CLEAR_ALL);

   `ECBCF_ASSERT_NOW(a_one_in_flight, rsp_valid, !req_ready, "request taken while busy")
   `ECBCF_ASSERT_NOW(a_empty_is_last, rsp_is_empty, rsp_last, "empty report not last")
   `ECBCF_ASSERT_NOW(a_entry_flag_cleared, rsp_is_entry, !flags_ff[rsp_counter_index], "flag kept")
   `ECBCF_ASSERT_NEXT(a_clear_all_flags, clear_all_exec, (&flags_ff) && !(|valid_ff), "not cleared")
   `ECBCF_ASSERT_NOW(a_single_last, rsp_valid && !scan_cont_ff, rsp_last, "last missing")

endmodule

`default_nettype wire
